// ===== rtl/ial_pkg.sv =====
// ---------------------------------------------------------------------------
// ial_pkg
// Shared types and constants for the indexed array list block.
// ---------------------------------------------------------------------------
`default_nettype none

package ial_pkg;

    // list geometry
    localparam int CAPACITY    = 256;
    localparam int ENTRY_WIDTH = 64;
    localparam int ADDR_W      = $clog2(CAPACITY);

    // fixed field widths of the channels
    localparam int ACTION_W = 3;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 64;
    localparam int COUNT_W  = 9;

    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [COUNT_W-1:0]     count_t;
    typedef logic [ENTRY_WIDTH-1:0] entry_t;

    // action codes carried by a request beat
    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND      = 3'd0,
        ACT_INSERT      = 3'd1,
        ACT_REMOVE_LAST = 3'd2,
        ACT_REMOVE_AT   = 3'd3,
        ACT_READ        = 3'd4
    } action_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_FINISH,
        ST_READ
    } state_t;

    // memory write and read port controls
    typedef struct packed {
        logic   en;
        addr_t  addr;
        entry_t data;
    } ram_wr_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
    } ram_rd_t;

endpackage

`default_nettype wire

// ===== rtl/ial_if.sv =====
// ---------------------------------------------------------------------------
// ial_if
// Request and response channel interfaces with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface ial_req_if;
    logic                            valid;
    logic                            ready;
    logic [ial_pkg::ACTION_W-1:0]    action;
    logic [ial_pkg::POS_W-1:0]       position;
    logic [ial_pkg::VALUE_W-1:0]     entry_value;

    modport source (output valid, output action, output position, output entry_value,
                    input ready);
    modport sink   (input valid, input action, input position, input entry_value,
                    output ready);
endinterface

interface ial_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [ial_pkg::VALUE_W-1:0]     read_value;
    logic                            ok;
    logic [ial_pkg::COUNT_W-1:0]     entry_count;

    modport source (output valid, output read_value, output ok, output entry_count,
                    input ready);
    modport sink   (input valid, input read_value, input ok, input entry_count,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/ial_ram.sv =====
// ---------------------------------------------------------------------------
// ial_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ial_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ial_ctrl.sv =====
// ---------------------------------------------------------------------------
// ial_ctrl
// Sequencer for the list: count, shift walk over the store, response register.
// ---------------------------------------------------------------------------
`default_nettype none

module ial_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    ial_req_if.sink               req,
    ial_rsp_if.source             rsp,
    output ial_pkg::ram_wr_t      ram_wr,
    output ial_pkg::ram_rd_t      ram_rd,
    input  wire ial_pkg::entry_t  ram_rdata
);

    ial_pkg::state_t  state_reg, state_next;
    ial_pkg::count_t  count_reg, count_next;
    ial_pkg::count_t  left_reg, left_next;
    ial_pkg::addr_t   rd_addr_reg, rd_addr_next;
    ial_pkg::addr_t   wr_addr_reg, wr_addr_next;
    ial_pkg::addr_t   pos_reg, pos_next;
    ial_pkg::entry_t  val_reg, val_next;
    logic             wr_pend_reg, wr_pend_next;
    logic             up_reg, up_next;

    logic                          out_valid_reg, out_valid_next;
    logic [ial_pkg::VALUE_W-1:0]   out_value_reg, out_value_next;
    logic                          out_ok_reg, out_ok_next;
    ial_pkg::count_t               out_count_reg, out_count_next;

    ial_pkg::action_t  act;
    ial_pkg::count_t   pos_c;
    ial_pkg::entry_t   val_in;
    logic              fire;

    assign act    = ial_pkg::action_t'(req.action);
    assign pos_c  = ial_pkg::COUNT_W'(req.position);
    assign val_in = req.entry_value[ial_pkg::ENTRY_WIDTH-1:0];

    assign req.ready = (state_reg == ial_pkg::ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign fire      = req.valid && req.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.entry_count = out_count_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ial_pkg::ST_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            wr_pend_reg   <= 1'b0;
            up_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            wr_pend_reg   <= wr_pend_next;
            up_reg        <= up_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_addr_reg   <= rd_addr_next;
        wr_addr_reg   <= wr_addr_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        out_value_reg <= out_value_next;
        out_ok_reg    <= out_ok_next;
        out_count_reg <= out_count_next;
    end

    // next state, memory accesses and response
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        rd_addr_next   = rd_addr_reg;
        wr_addr_next   = wr_addr_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        wr_pend_next   = wr_pend_reg;
        up_next        = up_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_ok_next    = out_ok_reg;
        out_count_next = out_count_reg;
        ram_wr.en      = 1'b0;
        ram_wr.addr    = wr_addr_reg;
        ram_wr.data    = ram_rdata;
        ram_rd.en      = 1'b0;
        ram_rd.addr    = rd_addr_reg;

        case (state_reg)
            ial_pkg::ST_IDLE:
            begin
                if (fire)
                begin
                    // refused by default, overridden below
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    out_ok_next    = 1'b0;
                    out_count_next = count_reg;
                    case (act)
                        ial_pkg::ACT_APPEND:
                        begin
                            if (count_reg < ial_pkg::COUNT_W'(ial_pkg::CAPACITY))
                            begin
                                ram_wr.en      = 1'b1;
                                ram_wr.addr    = count_reg[ial_pkg::ADDR_W-1:0];
                                ram_wr.data    = val_in;
                                count_next     = count_reg + 1'b1;
                                out_ok_next    = 1'b1;
                                out_count_next = count_reg + 1'b1;
                            end
                        end
                        ial_pkg::ACT_INSERT:
                        begin
                            if (count_reg < ial_pkg::COUNT_W'(ial_pkg::CAPACITY) &&
                                pos_c < count_reg)
                            begin
                                // walk down from the last entry, each moves up one
                                ram_rd.en      = 1'b1;
                                ram_rd.addr    = ial_pkg::ADDR_W'(count_reg - 1'b1);
                                rd_addr_next   = ial_pkg::ADDR_W'(count_reg - 2'd2);
                                wr_addr_next   = count_reg[ial_pkg::ADDR_W-1:0];
                                left_next      = count_reg - pos_c - 1'b1;
                                wr_pend_next   = 1'b1;
                                up_next        = 1'b1;
                                pos_next       = ial_pkg::ADDR_W'(req.position);
                                val_next       = val_in;
                                count_next     = count_reg + 1'b1;
                                out_valid_next = 1'b0;
                                state_next     = ial_pkg::ST_SHIFT;
                            end
                        end
                        ial_pkg::ACT_REMOVE_LAST:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next     = count_reg - 1'b1;
                                out_ok_next    = 1'b1;
                                out_count_next = count_reg - 1'b1;
                            end
                        end
                        ial_pkg::ACT_REMOVE_AT:
                        begin
                            if (pos_c < count_reg)
                            begin
                                count_next     = count_reg - 1'b1;
                                out_ok_next    = 1'b1;
                                out_count_next = count_reg - 1'b1;
                                if (pos_c + 1'b1 < count_reg)
                                begin
                                    // walk up from the removed slot, each moves down one
                                    ram_rd.en      = 1'b1;
                                    ram_rd.addr    = ial_pkg::ADDR_W'(pos_c + 1'b1);
                                    rd_addr_next   = ial_pkg::ADDR_W'(pos_c + 2'd2);
                                    wr_addr_next   = ial_pkg::ADDR_W'(req.position);
                                    left_next      = count_reg - pos_c - 2'd2;
                                    wr_pend_next   = 1'b1;
                                    up_next        = 1'b0;
                                    out_valid_next = 1'b0;
                                    state_next     = ial_pkg::ST_SHIFT;
                                end
                            end
                        end
                        ial_pkg::ACT_READ:
                        begin
                            if (pos_c < count_reg)
                            begin
                                ram_rd.en      = 1'b1;
                                ram_rd.addr    = ial_pkg::ADDR_W'(req.position);
                                out_valid_next = 1'b0;
                                state_next     = ial_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            out_ok_next = 1'b0;
                        end
                    endcase
                end
            end

            ial_pkg::ST_SHIFT:
            begin
                // write back the entry read last cycle
                ram_wr.en = wr_pend_reg;
                if (left_reg != '0)
                begin
                    ram_rd.en    = 1'b1;
                    ram_rd.addr  = rd_addr_reg;
                    wr_addr_next = up_reg ? rd_addr_reg + 1'b1 : rd_addr_reg - 1'b1;
                    rd_addr_next = up_reg ? rd_addr_reg - 1'b1 : rd_addr_reg + 1'b1;
                    left_next    = left_reg - 1'b1;
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (up_reg)
                    begin
                        state_next = ial_pkg::ST_FINISH;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = '0;
                        out_ok_next    = 1'b1;
                        out_count_next = count_reg;
                        state_next     = ial_pkg::ST_IDLE;
                    end
                end
            end

            ial_pkg::ST_FINISH:
            begin
                // drop the new entry into the opened slot
                ram_wr.en      = 1'b1;
                ram_wr.addr    = pos_reg;
                ram_wr.data    = val_reg;
                out_valid_next = 1'b1;
                out_value_next = '0;
                out_ok_next    = 1'b1;
                out_count_next = count_reg;
                state_next     = ial_pkg::ST_IDLE;
            end

            ial_pkg::ST_READ:
            begin
                out_valid_next = 1'b1;
                out_value_next = ial_pkg::VALUE_W'(ram_rdata);
                out_ok_next    = 1'b1;
                out_count_next = count_reg;
                state_next     = ial_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = ial_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/indexed_array_list_top.sv =====
// ---------------------------------------------------------------------------
// indexed_array_list_top
// Ordered list of word entries with append, insert, remove and indexed read.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one action per beat (append, insert before index, remove
//   last, remove at index, read); rsp returns exactly one beat per request
//   with the read data, an ok flag and the entry count after the action.
//   Append, remove last and every refused action answer straight from the
//   idle state; read answers through the registered port of the entry store.
//   Insert and remove at index p shift the entries from p to the end of the
//   list (remove at the last index needs no shift): the shift walks the store
//   one entry per cycle, one read and one write-back, and insert then writes
//   the new entry into the opened slot.
//   One request is in flight at a time; req.ready is high when the
//   sequencer is idle and the response register is empty or being drained,
//   so a new beat is taken in the same cycle a finished one is taken.
//   A stalled rsp holds its beat unchanged and blocks further requests.
//   Reset clears the count and the handshake state; the store needs no
//   clearing since only entries below the count are ever read.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_array_list_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ial_req_if.sink     req,
    ial_rsp_if.source   rsp
);

    ial_pkg::ram_wr_t  ram_wr;
    ial_pkg::ram_rd_t  ram_rd;
    ial_pkg::entry_t   ram_rdata;

    // sequencer and response register
    ial_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_wr    (ram_wr),
        .ram_rd    (ram_rd),
        .ram_rdata (ram_rdata)
    );

    // entry store
    ial_ram #(
        .DEPTH (ial_pkg::CAPACITY),
        .WIDTH (ial_pkg::ENTRY_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (ram_rd.en),
        .rd_addr (ram_rd.addr),
        .rd_data (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/ial_checker.sv =====
// ---------------------------------------------------------------------------
// ial_checker
// Port-level checks on the response channel of the indexed array list.
// ---------------------------------------------------------------------------
`default_nettype none

module ial_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [ial_pkg::VALUE_W-1:0]   rsp_read_value,
    input wire logic                          rsp_ok,
    input wire logic [ial_pkg::COUNT_W-1:0]   rsp_entry_count
);

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) &&
        $stable(rsp_ok) && $stable(rsp_entry_count))
        else $error("response changed while stalled");

    // count never exceeds the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_entry_count <= ial_pkg::COUNT_W'(ial_pkg::CAPACITY))
        else $error("entry count above capacity");

    // refused action returns no data
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_read_value == '0)
        else $error("refused action returned data");

    // empty list never returns data
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_entry_count == '0 |-> rsp_read_value == '0)
        else $error("data returned from empty list");

endmodule

bind indexed_array_list_top ial_checker u_ial_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_read_value  (rsp.read_value),
    .rsp_ok          (rsp.ok),
    .rsp_entry_count (rsp.entry_count)
);

`default_nettype wire
